// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked property, disabled while reset is asserted
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked property that also holds during reset
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== src/bia_pkg.sv =====
// ----------------------------------------------------------------------------
// bia_pkg
// Types and constants of the bitmap identifier allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int ID_COUNT_DEF = 256;
    localparam int MAX_WORD_W   = 64;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RMW  = 2'b10
    } t_state;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] release_id;
    } t_req;

    typedef struct packed {
        logic [7:0] granted_id;
        t_status    status;
        logic [8:0] in_use_count;
    } t_rsp;

endpackage

// ===== src/bia_mem.sv =====
// ----------------------------------------------------------------------------
// bia_mem
// Bitmap word memory, one synchronous read and one write port. Rows never
// written since reset read as all free through per-row valid bits.
// ----------------------------------------------------------------------------
module bia_mem #(
    parameter int ROWS   = 4,
    parameter int WORD_W = 64,
    parameter int ROW_AW = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ROW_AW-1:0] i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ROW_AW-1:0] i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_data
);
    logic [WORD_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]   r_row_valid;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_row_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== src/bia_summary.sv =====
// ----------------------------------------------------------------------------
// bia_summary
// One full flag per bitmap row and the search for the lowest row that
// still has a free identifier.
// ----------------------------------------------------------------------------
module bia_summary #(
    parameter int ROWS   = 4,
    parameter int ROW_AW = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_upd_en,
    input  logic [ROW_AW-1:0] i_upd_row,
    input  logic              i_upd_full,
    output logic              o_any_free,
    output logic [ROW_AW-1:0] o_free_row
);
    logic [ROWS-1:0] r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else if (i_upd_en) begin
            r_full[i_upd_row] <= i_upd_full;
        end
    end

    // lowest row whose full flag is clear
    always_comb begin
        o_free_row = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                o_free_row = ROW_AW'(i);
            end
        end
    end

    assign o_any_free = ~&r_full;

endmodule

// ===== src/bitmap_id_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// First-fit identifier allocator over a bitmap of in-use marks kept in a
// word memory, with a row summary for the lowest free row and a use count.
//
//   channel   handshake          payload
//   request   i_start / o_busy   i_req  (command, release_id)
//   result    o_done strobe      o_rsp  (granted_id, status, in_use_count)
//
// A transaction reads the bitmap row at the accept edge; the edge that
// leaves S_RMW writes it back and registers the result, so o_done is high
// once the state is back in S_IDLE and a new request is taken then.
// o_busy stays high during the read-modify-write, so requests do not overlap.
// Synchronous active-low reset empties the bitmap at once; no clearing pass.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module bitmap_id_allocator #(
    parameter int ID_COUNT = bia_pkg::ID_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  bia_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_done,
    output bia_pkg::t_rsp o_rsp
);
    import bia_pkg::*;

`include "assert_macros.svh"

    localparam int ID_AW     = $clog2(ID_COUNT);
    localparam int WORD_W    = (ID_COUNT < MAX_WORD_W) ? (2 ** ID_AW) : MAX_WORD_W;
    localparam int WORD_AW   = $clog2(WORD_W);
    localparam int ROWS      = (ID_COUNT + WORD_W - 1) / WORD_W;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W     = $clog2(ID_COUNT + 1);
    localparam int LAST_BITS = ID_COUNT - (ROWS - 1) * WORD_W;
    localparam logic [WORD_W-1:0] LAST_MASK =
        WORD_W'(((WORD_W + 1)'(1) << LAST_BITS) - (WORD_W + 1)'(1));

    t_state             r_state;
    t_cmd               r_cmd;
    logic [ROW_AW-1:0]  r_row;
    logic [WORD_AW-1:0] r_bit;
    logic               r_bad;
    logic [CNT_W-1:0]   r_count;
    logic               r_done;
    t_rsp               r_rsp;

    t_cmd               n_cmd;
    logic [ROW_AW-1:0]  n_row;
    logic               n_bad;
    logic [CNT_W-1:0]   n_count;
    t_rsp               n_rsp;

    logic                  accept;
    logic                  any_free;
    logic [ROW_AW-1:0]     free_row;
    logic [ID_AW+7:0]      rel_wide;
    logic [ID_AW-1:0]      rel_id;
    logic [ID_AW+ROW_AW-1:0] rel_row_wide;
    logic [WORD_W-1:0]     rd_word;
    logic [WORD_W-1:0]     row_mask;
    logic [WORD_W-1:0]     free_bits;
    logic [WORD_AW-1:0]    alloc_bit;
    logic [WORD_AW-1:0]    sel_bit;
    logic [WORD_W-1:0]     bit_onehot;
    logic [WORD_W-1:0]     new_word;
    logic                  wr_en;
    logic [ID_AW-1:0]      grant_id;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // release identifier split into row and bit
    assign rel_wide     = {ID_AW'(0), i_req.release_id};
    assign rel_id       = rel_wide[ID_AW-1:0];
    assign rel_row_wide = {ROW_AW'(0), rel_id};

    always_comb begin
        n_cmd = i_req.command;
        if (i_req.command == CMD_ALLOC) begin
            n_row = free_row;
            n_bad = !any_free;
        end else begin
            n_row = ROW_AW'(rel_row_wide >> WORD_AW);
            n_bad = (rel_wide >= (ID_AW + 8)'(ID_COUNT));
        end
    end

    bia_summary #(
        .ROWS   (ROWS),
        .ROW_AW (ROW_AW)
    ) u_summary (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd_en   (wr_en),
        .i_upd_row  (r_row),
        .i_upd_full (&(new_word | ~row_mask)),
        .o_any_free (any_free),
        .o_free_row (free_row)
    );

    bia_mem #(
        .ROWS   (ROWS),
        .WORD_W (WORD_W),
        .ROW_AW (ROW_AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (n_row),
        .o_rd_data (rd_word),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_row),
        .i_wr_data (new_word)
    );

    // pad bits past the last identifier count as used
    assign row_mask  = (r_row == ROW_AW'(ROWS - 1)) ? LAST_MASK : '1;
    assign free_bits = ~rd_word & row_mask;

    always_comb begin
        alloc_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                alloc_bit = WORD_AW'(i);
            end
        end
    end

    assign sel_bit    = (r_cmd == CMD_ALLOC) ? alloc_bit : r_bit;
    assign bit_onehot = WORD_W'(1) << sel_bit;
    assign grant_id   = ID_AW'({r_row, alloc_bit});

    always_comb begin
        wr_en    = 1'b0;
        new_word = rd_word;
        n_count  = r_count;
        n_rsp    = '{granted_id: 8'd0, status: ST_OK, in_use_count: 9'd0};
        if (r_cmd == CMD_ALLOC) begin
            if (r_bad) begin
                n_rsp.status = ST_FULL;
            end else begin
                wr_en            = 1'b1;
                new_word         = rd_word | bit_onehot;
                n_count          = r_count + CNT_W'(1);
                n_rsp.granted_id = 8'(grant_id);
            end
        end else begin
            if (r_bad || !rd_word[r_bit]) begin
                n_rsp.status = ST_INVALID;
            end else begin
                wr_en    = 1'b1;
                new_word = rd_word & ~bit_onehot;
                n_count  = r_count - CNT_W'(1);
            end
        end
        n_rsp.in_use_count = 9'(n_count);
        wr_en = wr_en && (r_state == S_RMW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    r_state <= S_IDLE;
                    r_count <= n_count;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
            r_row <= n_row;
            r_bit <= rel_id[WORD_AW-1:0];
            r_bad <= n_bad;
        end
        if (r_state == S_RMW) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `ASSERT_CLK(a_rmw_then_done, i_clk, i_rst_n, (r_state == S_RMW) |=> r_done, "read-modify-write not followed by result")
    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(ID_COUNT), "count above limit")
    `ASSERT_CLK(a_grant_counts, i_clk, i_rst_n, (r_done && r_cmd == CMD_ALLOC && r_rsp.status == ST_OK) |-> (r_count == $past(r_count) + CNT_W'(1)), "grant without count increment")
    `ASSERT_CLK(a_full_no_change, i_clk, i_rst_n, (r_done && r_rsp.status != ST_OK) |-> (r_count == $past(r_count)), "failed transaction changed count")

endmodule
